// ----- design/wwd_pkg.sv -----
// Shared types and constants for the whole-word delete filter.
package wwd_pkg;

  localparam int MAX_WORD_DEF = 32;
  localparam int KEY_BYTES    = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  localparam logic [7:0] SEP_CHAR = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS3 = 3'd4;

  // One request from the front part to the back part.
  typedef struct packed {
    logic       app;    // append ch to the word store
    logic       sep;    // emit a separating space first
    logic       flush;  // emit the buffered word
    logic       tail;   // emit ch after the buffered word
    logic       clr;    // empty the word store when done
    logic       last;   // closes the line
    logic [7:0] ch;
  } cmd_t;

endpackage

// ----- design/wwd_if.sv -----
// Handshake channels: text input, result output and configuration writes.
interface wwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       line_last;
  modport source (output valid, in_char, line_last, input ready);
  modport sink (input valid, in_char, line_last, output ready);
endinterface

interface wwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       line_end;
  logic       last_of_run;
  modport source (output valid, out_char, char_valid, line_end, last_of_run, input ready);
  modport sink (input valid, out_char, char_valid, line_end, last_of_run, output ready);
endinterface

interface wwd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wwd_pkg::CFG_IDX_W-1:0]  index;
  logic [wwd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/wwd_front.sv -----
// Front part: keyword registers, word tracking and request classification.
module wwd_front #(
  parameter int MAX_WORD = wwd_pkg::MAX_WORD_DEF
) (
  input  logic           clk,
  input  logic           rst,
  wwd_in_if.sink         in_ch,
  wwd_cfg_if.sink        cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output wwd_pkg::cmd_t  push_data
);
  import wwd_pkg::*;

  localparam int CntW = $clog2(MAX_WORD + 1);

  logic [5:0]       key_len;
  logic [3:0][63:0] key_chars;
  logic [CntW-1:0]  wc;
  logic             sm;
  logic             pt;
  logic             we;

  logic [CntW-1:0]  wc_next;
  logic             sm_next;
  logic             pt_next;
  logic             we_next;
  cmd_t             cmd;
  logic [6:0]       wc7;
  logic [6:0]       wct7;
  logic [7:0]       key_byte;
  logic             byte_ok;
  logic             match;
  logic             accept;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  assign cfg.ready    = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push_valid   = in_ch.valid;
  assign push_data    = cmd;
  assign accept       = in_ch.valid && push_ready;

  assign wc7      = 7'(wc);
  assign key_byte = key_chars[wc7[4:3]][{wc7[2:0], 3'b000} +: 8];
  assign byte_ok  = (wc7 < {1'b0, key_len}) && (wc7 < 7'(KEY_BYTES)) &&
                    (fold(in_ch.in_char) == fold(key_byte));

  always_comb begin
    cmd      = '0;
    cmd.ch   = in_ch.in_char;
    cmd.last = in_ch.line_last;
    wc_next  = wc;
    sm_next  = sm;
    pt_next  = pt;
    we_next  = we;
    match    = 1'b0;
    wct7     = 7'd0;
    if (in_ch.in_char != SEP_CHAR) begin
      if (pt) begin
        cmd.tail = 1'b1;
      end else if (wc == CntW'(MAX_WORD)) begin
        cmd.sep   = we;
        cmd.flush = 1'b1;
        cmd.tail  = 1'b1;
        cmd.clr   = 1'b1;
        pt_next   = 1'b1;
        wc_next   = '0;
        sm_next   = 1'b0;
        we_next   = 1'b1;
      end else begin
        cmd.app = 1'b1;
        sm_next = sm && byte_ok;
        wc_next = wc + 1'b1;
      end
    end
    if (in_ch.in_char == SEP_CHAR || in_ch.line_last) begin
      cmd.clr = 1'b1;
      wct7    = 7'(wc_next);
      match   = sm_next && (key_len != 6'd0) && (key_len <= 6'(KEY_BYTES)) &&
                (wct7 == {1'b0, key_len});
      if (!pt_next && wc_next != '0 && !match) begin
        cmd.sep   = we_next;
        cmd.flush = 1'b1;
        we_next   = 1'b1;
      end
      wc_next = '0;
      sm_next = 1'b1;
      pt_next = 1'b0;
    end
    if (in_ch.line_last) begin
      we_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc <= '0;
      sm <= 1'b1;
      pt <= 1'b0;
      we <= 1'b0;
    end else if (accept) begin
      wc <= wc_next;
      sm <= sm_next;
      pt <= pt_next;
      we <= we_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len   <= '0;
      key_chars <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KEY_LEN:    key_len      <= cfg.data[5:0];
        REG_KEY_CHARS0: key_chars[0] <= cfg.data;
        REG_KEY_CHARS1: key_chars[1] <= cfg.data;
        REG_KEY_CHARS2: key_chars[2] <= cfg.data;
        REG_KEY_CHARS3: key_chars[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  a_wc_bound: assert property (@(posedge clk) disable iff (rst)
    wc <= CntW'(MAX_WORD)) else $error("word count beyond buffer");
  a_pt_no_match: assert property (@(posedge clk) disable iff (rst)
    pt |-> (!sm && wc == '0)) else $error("pass-through word still matching");

endmodule

// ----- design/wwd_queue.sv -----
// Short request queue between the front and back parts.
module wwd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  wwd_pkg::cmd_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wwd_pkg::cmd_t  pop_data
);
  import wwd_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != CntW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/wwd_back.sv -----
// Back part: word store and result sequencer with output register.
module wwd_back #(
  parameter int MAX_WORD = wwd_pkg::MAX_WORD_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  wwd_pkg::cmd_t  pop_data,
  wwd_out_if.source      out_ch
);
  import wwd_pkg::*;

  localparam int CntW = $clog2(MAX_WORD + 1);
  localparam int IdxW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DISP  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_TAIL  = 4'b1000
  } state_t;

  logic [7:0]      store [MAX_WORD];
  logic [7:0]      rd_data;
  state_t          state;
  state_t          state_next;
  cmd_t            cmd;
  cmd_t            cmd_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;
  logic [CntW-1:0] pos;
  logic [CntW-1:0] pos_next;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic            out_free;
  logic            emit;
  logic [7:0]      e_char;
  logic            e_valid;
  logic            e_last;
  logic            finish;
  logic            at_end;

  logic            ov;
  logic [7:0]      o_char;
  logic            o_valid;
  logic            o_line_end;
  logic            o_last;

  assign out_free  = !ov || out_ch.ready;
  assign pop_ready = state == S_IDLE;
  assign wr_en     = (state == S_IDLE) && pop_valid && pop_data.app;
  assign rd_addr   = pos_next[IdxW-1:0];
  assign at_end    = (pos + 1'b1) == cnt;

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    cnt_next   = cnt;
    pos_next   = pos;
    emit       = 1'b0;
    e_char     = '0;
    e_valid    = 1'b0;
    e_last     = 1'b0;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        pos_next = '0;
        if (pop_valid) begin
          cmd_next   = pop_data;
          state_next = S_DISP;
          if (pop_data.app) begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      S_DISP: begin
        if (cmd.sep) begin
          if (out_free) begin
            emit    = 1'b1;
            e_char  = SEP_CHAR;
            e_valid = 1'b1;
            e_last  = !cmd.flush && !cmd.tail;
            if (cmd.flush) begin
              state_next = S_FLUSH;
            end else if (cmd.tail) begin
              state_next = S_TAIL;
            end else begin
              finish = 1'b1;
            end
          end
        end else if (cmd.flush) begin
          state_next = S_FLUSH;
        end else if (cmd.tail) begin
          state_next = S_TAIL;
        end else if (cmd.last) begin
          if (out_free) begin
            emit   = 1'b1;
            e_last = 1'b1;
            finish = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit    = 1'b1;
          e_char  = rd_data;
          e_valid = 1'b1;
          e_last  = at_end && !cmd.tail;
          if (at_end) begin
            if (cmd.tail) begin
              state_next = S_TAIL;
            end else begin
              finish = 1'b1;
            end
          end else begin
            pos_next = pos + 1'b1;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          emit    = 1'b1;
          e_char  = cmd.ch;
          e_valid = 1'b1;
          e_last  = 1'b1;
          finish  = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (finish) begin
      state_next = S_IDLE;
      if (cmd.clr) begin
        cnt_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cnt[IdxW-1:0]] <= pop_data.ch;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    if (emit) begin
      o_char     <= e_char;
      o_valid    <= e_valid;
      o_line_end <= e_last && cmd.last;
      o_last     <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pos   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = ov;
  assign out_ch.out_char    = o_char;
  assign out_ch.char_valid  = o_valid;
  assign out_ch.line_end    = o_line_end;
  assign out_ch.last_of_run = o_last;

  a_pos_in_word: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (pos < cnt)) else $error("flush beyond buffered word");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (ov && o_line_end) |-> o_last) else $error("line end not on last result");
  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    (ov && !o_valid) |-> (o_line_end && o_char == '0)) else $error("stray bare marker");

endmodule

// ----- design/whole_word_delete_filter.sv -----
// Top level of the whole-word delete filter.
//
//  channel  role    payload
//  in_ch    sink    in_char, line_last
//  out_ch   source  out_char, char_valid, line_end, last_of_run
//  cfg      sink    index, data (always ready)
//
// The back sequencer takes each request from IDLE through DISP, which sends any
// separating space, then FLUSH for the buffered word and TAIL for a byte passed
// straight through; a 2-entry queue lets the front keep taking bytes while a
// flush runs.
// Reset (rst, synchronous) clears control state and keyword registers; the
// word store is not cleared. Output stalls hold the output register.
module whole_word_delete_filter #(
  parameter int MAX_WORD = wwd_pkg::MAX_WORD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wwd_in_if.sink     in_ch,
  wwd_out_if.source  out_ch,
  wwd_cfg_if.sink    cfg
);
  import wwd_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  wwd_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  wwd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  wwd_back #(.MAX_WORD(MAX_WORD)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the whole-word delete filter: directed table, then random text.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wwd_pkg::*;

  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_SHIFT = 8'd32;
  localparam int         QUIET_CYCLES = 100;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       le;
    logic       lr;
  } out_rec_t;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0]            ch;
    logic                  last;
    bit                    typed;
    out_rec_t              want;
  } plan_row_t;

  logic clk;
  logic rst;

  wwd_in_if  in_if ();
  wwd_out_if out_if ();
  wwd_cfg_if cfg_if ();

  whole_word_delete_filter dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg    (cfg_if)
  );

  // filter state mirror
  logic [7:0]            word_buf [MAX_WORD_DEF];
  int unsigned           word_len;
  bit                    prefix_ok;
  bit                    streaming;
  bit                    line_has_word;
  logic [5:0]            key_len;
  logic [CFG_DATA_W-1:0] key_chars [4];

  out_rec_t  byte_out [$];
  out_rec_t  text_due [$];
  plan_row_t plan [$];

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int text_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_SHIFT : c;
  endfunction

  function automatic logic [7:0] key_char(int unsigned i);
    return key_chars[(i >> 3) & 3][(i & 7) * 8 +: 8];
  endfunction

  function automatic void emit_char(logic [7:0] c);
    byte_out.push_back('{ch: c, cv: 1'b1, le: 1'b0, lr: 1'b0});
  endfunction

  function automatic void emit_gap();
    if (line_has_word) begin
      emit_char(SEP_CHAR);
    end
    line_has_word = 1'b1;
  endfunction

  function automatic void flush_word();
    for (int i = 0; i < word_len; i++) emit_char(word_buf[i]);
  endfunction

  function automatic void clear_word();
    word_len  = 0;
    prefix_ok = 1'b1;
    streaming = 1'b0;
  endfunction

  function automatic void absorb_char(logic [7:0] c);
    if (streaming) begin
      emit_char(c);
    end else if (word_len >= MAX_WORD_DEF) begin
      emit_gap();
      flush_word();
      emit_char(c);
      streaming = 1'b1;
      word_len  = 0;
      prefix_ok = 1'b0;
    end else begin
      if (!(word_len < key_len && word_len < KEY_BYTES &&
            fold_case(c) == fold_case(key_char(word_len)))) begin
        prefix_ok = 1'b0;
      end
      word_buf[word_len] = c;
      word_len++;
    end
  endfunction

  function automatic void close_word();
    bit hit;
    if (!streaming && word_len > 0) begin
      hit = prefix_ok && key_len != 0 && key_len <= KEY_BYTES && word_len == key_len;
      if (!hit) begin
        emit_gap();
        flush_word();
      end
    end
    clear_word();
  endfunction

  function automatic void filter_byte(logic [7:0] c, logic last);
    out_rec_t r;
    byte_out.delete();
    if (c != SEP_CHAR) absorb_char(c);
    if (c == SEP_CHAR || last) close_word();
    if (last) begin
      if (byte_out.size() == 0) begin
        byte_out.push_back('{ch: 8'd0, cv: 1'b0, le: 1'b0, lr: 1'b0});
      end
      r = byte_out.pop_back();
      r.le = 1'b1;
      byte_out.push_back(r);
      clear_word();
      line_has_word = 1'b0;
    end
    if (byte_out.size() > 0) begin
      r = byte_out.pop_back();
      r.lr = 1'b1;
      byte_out.push_back(r);
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_KEY_LEN:    key_len = value[5:0];
      REG_KEY_CHARS0: key_chars[0] = value;
      REG_KEY_CHARS1: key_chars[1] = value;
      REG_KEY_CHARS2: key_chars[2] = value;
      REG_KEY_CHARS3: key_chars[3] = value;
      default: ;
    endcase
  endfunction

  function automatic out_rec_t out_rec(logic [7:0] c, logic cv, logic le, logic lr);
    return '{ch: c, cv: cv, le: le, lr: lr};
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    plan.push_back('{is_reg: 1'b1, idx: idx, data: value, ch: 8'd0, last: 1'b0,
                     typed: 1'b0, want: '0});
  endfunction

  function automatic void add_text(logic [7:0] c, logic last);
    plan.push_back('{is_reg: 1'b0, idx: REG_KEY_LEN, data: '0, ch: c, last: last,
                     typed: 1'b0, want: '0});
  endfunction

  function automatic void add_text_typed(logic [7:0] c, logic last, out_rec_t want);
    plan.push_back('{is_reg: 1'b0, idx: REG_KEY_LEN, data: '0, ch: c, last: last,
                     typed: 1'b1, want: want});
  endfunction

  function automatic void add_line(string s);
    for (int i = 0; i < s.len(); i++) add_text(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    if ($urandom_range(1)) begin
      c = $urandom_range(1) ? 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z))
                            : 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    end else begin
      c = 8'($urandom_range(255));
      if (c == SEP_CHAR) c = c + 8'd1;
    end
    return c;
  endfunction

  function automatic logic [7:0] flip_case_maybe(logic [7:0] c);
    if ($urandom_range(1)) begin
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_SHIFT;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CASE_SHIFT;
    end
    return c;
  endfunction

  function automatic void build_word(ref logic [7:0] w[$]);
    int pick;
    int n;
    w.delete();
    pick = $urandom_range(99);
    if (key_len >= 1 && key_len <= KEY_BYTES && pick < 60) begin
      for (int i = 0; i < key_len; i++) w.push_back(flip_case_maybe(key_char(i)));
      if (pick >= 40) begin
        case ($urandom_range(2))
          0: w.push_back(rand_text_char());
          1: if (w.size() > 1) void'(w.pop_back()); else w.push_back(rand_text_char());
          default: w[$urandom_range(w.size() - 1)] = rand_text_char();
        endcase
      end
    end else begin
      n = ($urandom_range(99) < 8) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      repeat (n) w.push_back(rand_text_char());
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg(idx, value);
  endtask

  task automatic send_text(input logic [7:0] c, input logic last, input bit typed,
                           input out_rec_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_char   <= c;
    in_if.line_last <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    filter_byte(c, last);
    if (typed) begin
      text_due.push_back(want);
    end else begin
      foreach (byte_out[i]) text_due.push_back(byte_out[i]);
    end
    text_sent++;
  endtask

  task automatic wait_for_idle();
    in_if.valid <= 1'b0;
    while (text_due.size() > 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic load_keyword(input logic [5:0] len);
    logic [CFG_DATA_W-1:0] chars [4];
    for (int i = 0; i < KEY_BYTES; i++) chars[i / 8][(i % 8) * 8 +: 8] = rand_text_char();
    write_reg(REG_KEY_LEN, CFG_DATA_W'(len));
    write_reg(REG_KEY_CHARS0, chars[0]);
    write_reg(REG_KEY_CHARS1, chars[1]);
    write_reg(REG_KEY_CHARS2, chars[2]);
    write_reg(REG_KEY_CHARS3, chars[3]);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_line();
    logic [7:0] line_q [$];
    logic [7:0] w [$];
    int n_words;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        line_q.push_back(($urandom_range(2) == 0) ? SEP_CHAR : 8'($urandom_range(255)));
      end
    end else begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) line_q.push_back(SEP_CHAR);
      n_words = $urandom_range(0, 5);
      for (int k = 0; k < n_words; k++) begin
        if (k > 0) begin
          repeat (($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1) line_q.push_back(SEP_CHAR);
        end
        build_word(w);
        foreach (w[j]) line_q.push_back(w[j]);
      end
      if ($urandom_range(3) == 0 || line_q.size() == 0) begin
        repeat ($urandom_range(1, 2)) line_q.push_back(SEP_CHAR);
      end
    end
    foreach (line_q[j]) send_text(line_q[j], j == line_q.size() - 1, 1'b0, '0);
  endtask

  task automatic run_phase(input int budget);
    logic [7:0] w [$];
    int start;
    start = text_sent;
    while (text_sent - start < budget) send_line();
    // leave a word open so the next keyword lands mid-word
    if ($urandom_range(1)) begin
      build_word(w);
      for (int j = 0; j < w.size() && j < 3; j++) send_text(w[j], 1'b0, 1'b0, '0);
    end
  endtask

  task automatic run_plan();
    bit reg_open;
    reg_open = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!reg_open) wait_for_idle();
        write_reg(plan[i].idx, plan[i].data);
        reg_open = 1'b1;
      end else begin
        if (reg_open) begin
          cfg_if.valid <= 1'b0;
          reg_open = 1'b0;
        end
        send_text(plan[i].ch, plan[i].last, plan[i].typed, plan[i].want);
      end
    end
  endtask

  // result checker and output stall
  initial begin
    out_rec_t got;
    out_rec_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_if.valid && out_if.ready) begin
        got = '{ch: out_if.out_char, cv: out_if.char_valid, le: out_if.line_end,
                lr: out_if.last_of_run};
        if (text_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result ch=%02h cv=%b le=%b lr=%b",
                                    got.ch, got.cv, got.le, got.lr));
        end else begin
          want = text_due.pop_front();
          if (got.ch !== want.ch || got.cv !== want.cv || got.le !== want.le ||
              got.lr !== want.lr) begin
            report_mismatch($sformatf("result ch=%02h cv=%b le=%b lr=%b, want %02h %b %b %b",
                                      got.ch, got.cv, got.le, got.lr,
                                      want.ch, want.cv, want.le, want.lr));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    logic [5:0] phase_len [6];
    in_if.valid     <= 1'b0;
    in_if.in_char   <= 8'd0;
    in_if.line_last <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_KEY_LEN;
    cfg_if.data     <= '0;
    rst             <= 1'b1;
    mismatches = 0;
    text_sent  = 0;
    word_buf   = '{default: 8'd0};
    key_len    = '0;
    key_chars  = '{default: '0};
    line_has_word = 1'b0;
    clear_word();
    send_idle_pct = 37;
    stall_pct     = 74;

    // keyword disabled after reset
    add_text_typed(SEP_CHAR, 1'b1, out_rec(8'd0, 1'b0, 1'b1, 1'b1));
    add_text_typed("x", 1'b1, out_rec("x", 1'b1, 1'b1, 1'b1));
    add_text_typed(8'hFF, 1'b1, out_rec(8'hFF, 1'b1, 1'b1, 1'b1));
    add_text_typed(8'h00, 1'b1, out_rec(8'h00, 1'b1, 1'b1, 1'b1));
    add_reg(REG_KEY_LEN, 64'd3);
    add_reg(REG_KEY_CHARS0, 64'h0000_0000_0065_4874);
    add_reg(REG_KEY_CHARS1, '1);
    add_reg(REG_KEY_CHARS2, '1);
    add_reg(REG_KEY_CHARS3, '1);
    add_line(" THE the cat ");
    // keyword rewritten between the two bytes of a word
    add_reg(REG_KEY_LEN, 64'd2);
    add_reg(REG_KEY_CHARS0, 64'h6261);
    add_text("A", 1'b0);
    add_reg(REG_KEY_CHARS0, 64'h627A);
    add_text_typed("b", 1'b1, out_rec(8'd0, 1'b0, 1'b1, 1'b1));
    // length above the key store matches nothing
    add_reg(REG_KEY_LEN, 64'd63);
    add_line("ab");
    // high bytes and the bytes next to the folded range compare literally; Z still folds
    add_reg(REG_KEY_LEN, 64'd1);
    add_reg(REG_KEY_CHARS0, 64'hC1);
    add_text_typed(8'hE1, 1'b1, out_rec(8'hE1, 1'b1, 1'b1, 1'b1));
    add_text_typed(8'hC1, 1'b1, out_rec(8'd0, 1'b0, 1'b1, 1'b1));
    add_reg(REG_KEY_CHARS0, 64'h40);
    add_text_typed(8'h60, 1'b1, out_rec(8'h60, 1'b1, 1'b1, 1'b1));
    add_reg(REG_KEY_CHARS0, 64'h7A);
    add_text_typed("Z", 1'b1, out_rec(8'd0, 1'b0, 1'b1, 1'b1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_plan();

    phase_len[0] = 6'd0;
    phase_len[1] = 6'd32;
    phase_len[2] = 6'($urandom_range(1, 6));
    phase_len[3] = 6'd63;
    phase_len[4] = 6'd1;
    phase_len[5] = 6'($urandom_range(2, 8));
    for (int p = 0; p < 6; p++) begin
      if (p >= 4) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if (p >= 2) begin
        send_idle_pct = 74;
        stall_pct     = 37;
      end
      wait_for_idle();
      load_keyword(phase_len[p]);
      run_phase(70);
    end
    wait_for_idle();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
